[rtl/core/ccc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar clock counter package
// Shared calendar record type and byte decode / month length helpers.
// ----------------------------------------------------------------------------
package ccc_pkg;

  localparam int unsigned SecMax   = 59;
  localparam int unsigned MinMax   = 59;
  localparam int unsigned HourMax  = 23;
  localparam int unsigned HourNoon = 12;
  localparam int unsigned MonthMax = 12;
  localparam int unsigned YearMax  = 99;
  localparam int unsigned Feb      = 2;

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [4:0] day;
    logic [3:0] month;
    logic [6:0] year;
  } cal_time_t;

  // BCD nibbles are weighted high*10 + low, even above 9
  function automatic logic [7:0] byte_decode(input logic [7:0] v, input logic bin);
    logic [7:0] r;
    if (bin) begin
      r = v;
    end else begin
      r = {1'b0, v[7:4], 3'b000} + {3'b000, v[7:4], 1'b0} + {4'b0000, v[3:0]};
    end
    return r;
  endfunction

  function automatic logic [4:0] days_in(input logic [3:0] m, input logic [6:0] y);
    logic [4:0] d;
    case (m)
      4'd2:    d = (y[1:0] == 2'b00) ? 5'd29 : 5'd28;
      4'd4:    d = 5'd30;
      4'd6:    d = 5'd30;
      4'd9:    d = 5'd30;
      4'd11:   d = 5'd30;
      default: d = 5'd31;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

[rtl/core/ccc_load_dec.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Load decoder
// Turns raw clock-chip bytes into a saturated 24-hour calendar record.
// ----------------------------------------------------------------------------
module ccc_load_dec import ccc_pkg::*; (
  input  wire logic       binary_mode,
  input  wire logic [7:0] raw_second,
  input  wire logic [7:0] raw_minute,
  input  wire logic [7:0] raw_hour,
  input  wire logic [7:0] raw_day,
  input  wire logic [7:0] raw_month,
  input  wire logic [7:0] raw_year,
  output cal_time_t       cal
);

  logic [7:0] sec_d, min_d, hour_d, day_d, mon_d, year_d;
  logic [7:0] hour_adj;
  logic [3:0] mon_c;
  logic [6:0] year_c;
  logic [4:0] dlen;

  always_comb begin
    sec_d  = byte_decode(raw_second, binary_mode);
    min_d  = byte_decode(raw_minute, binary_mode);
    hour_d = byte_decode({1'b0, raw_hour[6:0]}, binary_mode);
    day_d  = byte_decode(raw_day, binary_mode);
    mon_d  = byte_decode(raw_month, binary_mode);
    year_d = byte_decode(raw_year, binary_mode);

    // 12 AM -> 0, PM adds 12 except at noon
    if (raw_hour[7]) begin
      hour_adj = (hour_d == 8'(HourNoon)) ? hour_d : hour_d + 8'(HourNoon);
    end else begin
      hour_adj = (hour_d == 8'(HourNoon)) ? 8'd0 : hour_d;
    end

    if (mon_d == 8'd0) begin
      mon_c = 4'd1;
    end else if (mon_d > 8'(MonthMax)) begin
      mon_c = 4'(MonthMax);
    end else begin
      mon_c = mon_d[3:0];
    end
    year_c = (year_d > 8'(YearMax)) ? 7'(YearMax) : year_d[6:0];
    dlen   = days_in(mon_c, year_c);

    cal.sec   = (sec_d > 8'(SecMax)) ? 6'(SecMax) : sec_d[5:0];
    cal.min   = (min_d > 8'(MinMax)) ? 6'(MinMax) : min_d[5:0];
    cal.hour  = (hour_adj > 8'(HourMax)) ? 5'(HourMax) : hour_adj[4:0];
    cal.month = mon_c;
    cal.year  = year_c;
    if (day_d == 8'd0) begin
      cal.day = 5'd1;
    end else if (day_d > {3'b000, dlen}) begin
      cal.day = dlen;
    end else begin
      cal.day = day_d[4:0];
    end
  end

endmodule
`default_nettype wire

[rtl/core/ccc_tick_adv.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tick advance
// Adds one second to a calendar record with carry through to the year.
// ----------------------------------------------------------------------------
module ccc_tick_adv import ccc_pkg::*; (
  input  cal_time_t cur,
  output cal_time_t nxt
);

  logic sec_wrap, min_wrap, hour_wrap, day_wrap, mon_wrap;

  always_comb begin
    sec_wrap  = (cur.sec == 6'(SecMax));
    min_wrap  = sec_wrap && (cur.min == 6'(MinMax));
    hour_wrap = min_wrap && (cur.hour == 5'(HourMax));
    day_wrap  = hour_wrap && (cur.day >= days_in(cur.month, cur.year));
    mon_wrap  = day_wrap && (cur.month >= 4'(MonthMax));

    nxt = cur;
    nxt.sec = sec_wrap ? 6'd0 : cur.sec + 6'd1;
    if (sec_wrap) begin
      nxt.min = min_wrap ? 6'd0 : cur.min + 6'd1;
    end
    if (min_wrap) begin
      nxt.hour = hour_wrap ? 5'd0 : cur.hour + 5'd1;
    end
    if (hour_wrap) begin
      nxt.day = day_wrap ? 5'd1 : cur.day + 5'd1;
    end
    if (day_wrap) begin
      nxt.month = mon_wrap ? 4'd1 : cur.month + 4'd1;
    end
    if (mon_wrap) begin
      nxt.year = (cur.year >= 7'(YearMax)) ? 7'd0 : cur.year + 7'd1;
    end
  end

endmodule
`default_nettype wire

[rtl/core/calendar_clock_counter_top.sv]
// A request passes through the input register, then the result register;
// throughput one request per cycle while the output is not stalled.
// The calendar state is updated in the same cycle the result register loads,
// so a tick directly following a load or tick sees the new time.
// Synchronous active-low reset: time 00:00:00, day 1, month 1, year 0,
// tick count 0, BCD mode; both stages empty.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar clock counter top level
// Input register, load/tick logic, calendar state and result register.
// ----------------------------------------------------------------------------
module calendar_clock_counter_top import ccc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_action,
  input  wire logic [7:0]  in_raw_second,
  input  wire logic [7:0]  in_raw_minute,
  input  wire logic [7:0]  in_raw_hour,
  input  wire logic [7:0]  in_raw_day,
  input  wire logic [7:0]  in_raw_month,
  input  wire logic [7:0]  in_raw_year,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [5:0]       out_cur_second,
  output logic [5:0]       out_cur_minute,
  output logic [4:0]       out_cur_hour,
  output logic [4:0]       out_cur_day,
  output logic [3:0]       out_cur_month,
  output logic [6:0]       out_cur_year,
  output logic [63:0]      out_tick_total
);

  logic       binary_mode_r;
  logic       in_v_r;
  logic       act_r;
  logic [7:0] rsec_r, rmin_r, rhour_r, rday_r, rmon_r, ryear_r;

  cal_time_t   cal_r, cal_nxt, load_cal, tick_cal;
  logic [63:0] tick_r, tick_nxt;

  logic       out_v_r;
  cal_time_t  res_r;
  logic [63:0] res_tick_r;

  logic out_free, adv;

  assign out_free = !out_v_r || out_ready;
  assign adv      = in_v_r && out_free;
  assign in_ready = !in_v_r || adv;

  ccc_load_dec u_load (
    .binary_mode (binary_mode_r),
    .raw_second  (rsec_r),
    .raw_minute  (rmin_r),
    .raw_hour    (rhour_r),
    .raw_day     (rday_r),
    .raw_month   (rmon_r),
    .raw_year    (ryear_r),
    .cal         (load_cal)
  );

  ccc_tick_adv u_tick (
    .cur (cal_r),
    .nxt (tick_cal)
  );

  always_comb begin
    cal_nxt  = act_r ? load_cal : tick_cal;
    tick_nxt = act_r ? tick_r : tick_r + 64'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      binary_mode_r <= 1'b0;
      in_v_r        <= 1'b0;
      out_v_r       <= 1'b0;
      cal_r         <= '{sec: 6'd0, min: 6'd0, hour: 5'd0, day: 5'd1, month: 4'd1,
                         year: 7'd0};
      tick_r        <= 64'd0;
    end else begin
      if (cfg_we) begin
        binary_mode_r <= cfg_wdata;
      end
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (out_free) begin
        out_v_r <= in_v_r;
      end
      if (adv) begin
        cal_r  <= cal_nxt;
        tick_r <= tick_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      act_r   <= in_action;
      rsec_r  <= in_raw_second;
      rmin_r  <= in_raw_minute;
      rhour_r <= in_raw_hour;
      rday_r  <= in_raw_day;
      rmon_r  <= in_raw_month;
      ryear_r <= in_raw_year;
    end
    if (adv) begin
      res_r      <= cal_nxt;
      res_tick_r <= tick_nxt;
    end
  end

  assign out_valid      = out_v_r;
  assign out_cur_second = res_r.sec;
  assign out_cur_minute = res_r.min;
  assign out_cur_hour   = res_r.hour;
  assign out_cur_day    = res_r.day;
  assign out_cur_month  = res_r.month;
  assign out_cur_year   = res_r.year;
  assign out_tick_total = res_tick_r;

endmodule
`default_nettype wire

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar clock counter testbench
// Drives load and tick requests with random gaps on both channels (no gaps in
// one phase), predicts the calendar time and tick count after each request,
// and checks every result in order. BCD and binary load modes are both
// exercised, with mode changes only while the block is drained.
// ----------------------------------------------------------------------------
module tb_top;
  import ccc_pkg::*;

  localparam bit ActTick = 1'b0;
  localparam bit ActLoad = 1'b1;
  localparam bit ModeBcd = 1'b0;
  localparam bit ModeBin = 1'b1;
  localparam int DrainSlack = 4;
  localparam int PhaseItems = 150;
  localparam longint CycleLimit = 400000;

  typedef struct packed {
    cal_time_t   t;
    logic [63:0] ticks;
  } cal_result_t;

  class calendar_scoreboard;
    cal_time_t   now;
    logic [63:0] tick_count;
    bit          bin_mode;
    cal_result_t expected_times[$];
    int          errors;

    function new();
      now.sec    = 6'd0;
      now.min    = 6'd0;
      now.hour   = 5'd0;
      now.day    = 5'd1;
      now.month  = 4'd1;
      now.year   = 7'd0;
      tick_count = 64'd0;
      bin_mode   = ModeBcd;
      errors     = 0;
    endfunction

    static function int month_days(int m, int y);
      if (m == Feb && (y % 4) == 0) return 29;
      case (m)
        2:          return 28;
        4, 6, 9, 11: return 30;
        default:    return 31;
      endcase
    endfunction

    function int decode_byte(logic [7:0] v);
      if (bin_mode == ModeBin) return int'(v);
      return int'(v[3:0]) + int'(v[7:4]) * 10;
    endfunction

    function int clamp(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function void apply_load(logic [7:0] rs, logic [7:0] rm, logic [7:0] rh,
                             logic [7:0] rd, logic [7:0] rmo, logic [7:0] ry);
      int h;
      int mo;
      int y;
      now.sec  = 6'(clamp(decode_byte(rs), 0, SecMax));
      now.min  = 6'(clamp(decode_byte(rm), 0, MinMax));
      h = decode_byte({1'b0, rh[6:0]});
      if (rh[7]) begin
        if (h != HourNoon) h = h + 12;
      end else if (h == HourNoon) begin
        h = 0;
      end
      now.hour  = 5'(clamp(h, 0, HourMax));
      mo = clamp(decode_byte(rmo), 1, MonthMax);
      y  = clamp(decode_byte(ry), 0, YearMax);
      now.month = 4'(mo);
      now.year  = 7'(y);
      now.day   = 5'(clamp(decode_byte(rd), 1, month_days(mo, y)));
    endfunction

    function void advance_second();
      tick_count = tick_count + 64'd1;
      if (now.sec < SecMax) begin
        now.sec++;
        return;
      end
      now.sec = 6'd0;
      if (now.min < MinMax) begin
        now.min++;
        return;
      end
      now.min = 6'd0;
      if (now.hour < HourMax) begin
        now.hour++;
        return;
      end
      now.hour = 5'd0;
      if (int'(now.day) < month_days(int'(now.month), int'(now.year))) begin
        now.day++;
        return;
      end
      now.day = 5'd1;
      if (now.month < MonthMax) begin
        now.month++;
        return;
      end
      now.month = 4'd1;
      now.year  = (now.year >= YearMax) ? 7'd0 : now.year + 7'd1;
    endfunction

    function void note_request(bit act, logic [7:0] rs, logic [7:0] rm, logic [7:0] rh,
                               logic [7:0] rd, logic [7:0] rmo, logic [7:0] ry);
      cal_result_t r;
      if (act == ActLoad) apply_load(rs, rm, rh, rd, rmo, ry);
      else advance_second();
      r.t     = now;
      r.ticks = tick_count;
      expected_times.push_back(r);
    endfunction

    function int pending();
      return expected_times.size();
    endfunction

    task report(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(cal_result_t got);
      cal_result_t exp_r;
      if (expected_times.size() == 0) begin
        report("result with no request outstanding");
        return;
      end
      exp_r = expected_times.pop_front();
      if (got.t.sec != exp_r.t.sec)
        report($sformatf("second got %0d want %0d", got.t.sec, exp_r.t.sec));
      if (got.t.min != exp_r.t.min)
        report($sformatf("minute got %0d want %0d", got.t.min, exp_r.t.min));
      if (got.t.hour != exp_r.t.hour)
        report($sformatf("hour got %0d want %0d", got.t.hour, exp_r.t.hour));
      if (got.t.day != exp_r.t.day)
        report($sformatf("day got %0d want %0d", got.t.day, exp_r.t.day));
      if (got.t.month != exp_r.t.month)
        report($sformatf("month got %0d want %0d", got.t.month, exp_r.t.month));
      if (got.t.year != exp_r.t.year)
        report($sformatf("year got %0d want %0d", got.t.year, exp_r.t.year));
      if (got.ticks !== exp_r.ticks)
        report($sformatf("tick total got %0d want %0d", got.ticks, exp_r.ticks));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic        in_action;
  logic [7:0]  in_raw_second;
  logic [7:0]  in_raw_minute;
  logic [7:0]  in_raw_hour;
  logic [7:0]  in_raw_day;
  logic [7:0]  in_raw_month;
  logic [7:0]  in_raw_year;
  logic        out_valid;
  logic        out_ready;
  logic [5:0]  out_cur_second;
  logic [5:0]  out_cur_minute;
  logic [4:0]  out_cur_hour;
  logic [4:0]  out_cur_day;
  logic [3:0]  out_cur_month;
  logic [6:0]  out_cur_year;
  logic [63:0] out_tick_total;

  calendar_scoreboard sb;
  bit     cur_mode;
  bit     no_idle;
  int     phase_count;
  longint cycle_count;

  calendar_clock_counter_top DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_action      (in_action),
    .in_raw_second  (in_raw_second),
    .in_raw_minute  (in_raw_minute),
    .in_raw_hour    (in_raw_hour),
    .in_raw_day     (in_raw_day),
    .in_raw_month   (in_raw_month),
    .in_raw_year    (in_raw_year),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_cur_second (out_cur_second),
    .out_cur_minute (out_cur_minute),
    .out_cur_hour   (out_cur_hour),
    .out_cur_day    (out_cur_day),
    .out_cur_month  (out_cur_month),
    .out_cur_year   (out_cur_year),
    .out_tick_total (out_tick_total)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // mostly short gaps, a few long ones
  function int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function logic [7:0] enc_byte(int v, bit bin);
    if (bin == ModeBin) return 8'(v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  // 24-hour value to clock-chip 12-hour byte with PM in bit 7
  function logic [7:0] enc_hour(int h, bit bin);
    int h12;
    h12 = h % 12;
    if (h12 == 0) h12 = 12;
    return {(h >= 12), 7'd0} | enc_byte(h12, bin);
  endfunction

  always @(posedge clk) begin
    cal_result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.t.sec   = out_cur_second;
      got.t.min   = out_cur_minute;
      got.t.hour  = out_cur_hour;
      got.t.day   = out_cur_day;
      got.t.month = out_cur_month;
      got.t.year  = out_cur_year;
      got.ticks   = out_tick_total;
      sb.check_result(got);
    end
  end

  initial begin
    int gap;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      out_ready = 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      gap = no_idle ? 0 : gap_len();
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  end

  // called at a falling edge; returns at a falling edge
  task send_raw(bit act, logic [7:0] rs, logic [7:0] rm, logic [7:0] rh,
                logic [7:0] rd, logic [7:0] rmo, logic [7:0] ry);
    int gap;
    in_action     = act;
    in_raw_second = rs;
    in_raw_minute = rm;
    in_raw_hour   = rh;
    in_raw_day    = rd;
    in_raw_month  = rmo;
    in_raw_year   = ry;
    in_valid      = 1'b1;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    sb.note_request(act, rs, rm, rh, rd, rmo, ry);
    phase_count++;
    @(negedge clk);
    gap = no_idle ? 0 : gap_len();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task send_tick();
    send_raw(ActTick, 8'($urandom), 8'($urandom), 8'($urandom),
             8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  task send_load(int s, int m, int h, int d, int mo, int y);
    send_raw(ActLoad, enc_byte(s, cur_mode), enc_byte(m, cur_mode), enc_hour(h, cur_mode),
             enc_byte(d, cur_mode), enc_byte(mo, cur_mode), enc_byte(y, cur_mode));
  endtask

  task drain();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DrainSlack) @(negedge clk);
  endtask

  task set_mode(bit m);
    drain();
    cfg_we    = 1'b1;
    cfg_wdata = m;
    @(negedge clk);
    cfg_we    = 1'b0;
    cur_mode  = m;
    sb.bin_mode = m;
  endtask

  task random_phase(bit m);
    int r;
    int mo;
    int y;
    int md;
    set_mode(m);
    phase_count = 0;
    while (phase_count < PhaseItems) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        // load close to a rollover, then run ticks across it
        mo = $urandom_range(1, 12);
        r  = $urandom_range(0, 99);
        if (r < 20) y = 99;
        else if (r < 50) y = $urandom_range(0, 24) * 4;
        else y = $urandom_range(0, 99);
        md = calendar_scoreboard::month_days(mo, y);
        send_load($urandom_range(45, 59),
                  ($urandom_range(0, 9) < 7) ? 59 : $urandom_range(0, 59),
                  ($urandom_range(0, 9) < 7) ? 23 : $urandom_range(0, 23),
                  ($urandom_range(0, 9) < 7) ? md : $urandom_range(1, md),
                  mo, y);
        repeat ($urandom_range(1, 20)) send_tick();
      end else if (r < 75) begin
        send_tick();
      end else if (r < 90) begin
        mo = $urandom_range(1, 12);
        y  = $urandom_range(0, 99);
        send_load($urandom_range(0, 59), $urandom_range(0, 59), $urandom_range(0, 23),
                  $urandom_range(1, calendar_scoreboard::month_days(mo, y)), mo, y);
      end else begin
        send_raw(ActLoad, 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom), 8'($urandom), 8'($urandom));
      end
      if ($urandom_range(0, 99) < 2) drain();
    end
  endtask

  initial begin
    sb            = new();
    cycle_count   = 0;
    cur_mode      = ModeBcd;
    no_idle       = 1'b0;
    phase_count   = 0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_wdata     = 1'b0;
    in_valid      = 1'b0;
    in_action     = ActTick;
    in_raw_second = 8'd0;
    in_raw_minute = 8'd0;
    in_raw_hour   = 8'd0;
    in_raw_day    = 8'd0;
    in_raw_month  = 8'd0;
    in_raw_year   = 8'd0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // BCD directed
    send_tick();
    set_mode(ModeBcd);
    send_raw(ActLoad, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    send_raw(ActLoad, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_raw(ActLoad, 8'h30, 8'h15, 8'h12, 8'h10, 8'h06, 8'h21);
    send_raw(ActLoad, 8'h30, 8'h15, 8'h92, 8'h10, 8'h06, 8'h21);
    send_raw(ActLoad, 8'h59, 8'h59, 8'h91, 8'h31, 8'h12, 8'h98);
    send_raw(ActLoad, 8'h1A, 8'h3F, 8'h0C, 8'h1F, 8'h0B, 8'h9A);
    send_load(59, 59, 23, 31, 12, 99);
    send_tick();
    send_load(59, 59, 23, 28, 2, 1);
    send_tick();
    send_load(59, 59, 23, 28, 2, 4);
    send_tick();
    send_load(59, 59, 23, 29, 2, 4);
    send_tick();
    send_raw(ActLoad, 8'h00, 8'h00, 8'h00, 8'h31, 8'h02, 8'h03);
    send_raw(ActLoad, 8'h00, 8'h00, 8'h00, 8'h31, 8'h04, 8'h03);
    send_load(59, 59, 23, 30, 4, 3);
    send_tick();

    // binary directed
    set_mode(ModeBin);
    send_raw(ActLoad, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    send_raw(ActLoad, 8'd0, 8'd0, 8'h0C, 8'd0, 8'd0, 8'd0);
    send_raw(ActLoad, 8'd59, 8'd59, 8'h8C, 8'd29, 8'd2, 8'd96);
    send_raw(ActLoad, 8'd60, 8'd60, 8'h80, 8'd31, 8'd13, 8'd100);
    send_raw(ActLoad, 8'd59, 8'd59, 8'h8B, 8'd31, 8'd12, 8'd99);
    send_tick();

    random_phase(ModeBcd);
    random_phase(ModeBin);
    no_idle = 1'b1;
    random_phase(ModeBcd);
    no_idle = 1'b0;
    random_phase(ModeBin);

    drain();
    repeat (8) @(posedge clk);
    if (sb.pending() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
